### sv/access_rule_table_checker_defines.svh
// assertion macros for the access rule table checker
`ifndef ACCESS_RULE_TABLE_CHECKER_DEFINES_SVH
`define ACCESS_RULE_TABLE_CHECKER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ARTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ARTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/artc_pkg.sv
package artc_pkg;

    localparam int MAX_RULES = 64;
    localparam int IDX_W     = $clog2(MAX_RULES);
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    typedef enum logic [1:0] {
        OP_CHECK = 2'd0,
        OP_ADD   = 2'd1,
        OP_DEL   = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_EXACT   = 2'd0,
        KIND_NETWORK = 2'd1,
        KIND_COUNTRY = 2'd2,
        KIND_ASN     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_REDUCE,
        ST_OUT
    } state_t;

    localparam logic [2:0] TARGET_SYSTEM = 3'd0;

    typedef struct packed {
        logic [31:0] ident;
        kind_t       kind;
        logic [2:0]  target;
        logic        allow;
        logic        enabled;
        logic [31:0] address;
        logic [31:0] mask;
        logic [15:0] country;
        logic [31:0] asn;
    } rule_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [2:0]  target;
        logic [31:0] ip;
        logic [15:0] ctry_fold;
        logic        ctry_ok;
        logic [31:0] asn;
    } req_t;

    typedef struct packed {
        logic deny_hit;
        logic allow_any;
        logic allow_hit;
    } flags_t;

    typedef struct packed {
        logic eval_en;
        logic wr_en;
        logic kill_en;
        logic clear;
    } cell_ctl_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [15:0] fold_code(input logic [15:0] c);
        return {fold_byte(c[15:8]), fold_byte(c[7:0])};
    endfunction

endpackage

### sv/access_rule_table_checker.sv
// sequence: an accepted item passes through the eval and reduce states to the output state;
//   a system-first check that passes its system-wide pass runs eval and reduce again
//   (a system-wide denial ends it after the first pass)
// throughput: one item at a time; a new item is taken only after the last result is taken
// reset: synchronous active-low aresetn clears all live bits, slot and live counts,
//   check and denial counters and the control state; rule payload is not cleared
module access_rule_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_rule_id,
    input  logic [2:0]  s_target,
    input  logic [1:0]  s_rule_kind,
    input  logic        s_rule_allow,
    input  logic        s_rule_enabled,
    input  logic [31:0] s_ip_value,
    input  logic [31:0] s_mask_value,
    input  logic [15:0] s_country,
    input  logic        s_country_present,
    input  logic [31:0] s_asn,
    input  logic        s_system_first,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_allowed,
    output logic [1:0]  m_status,
    output logic [6:0]  m_rules_live,
    output logic [31:0] m_checks_total,
    output logic [31:0] m_denials_total
);
    import artc_pkg::*;

    `include "access_rule_table_checker_defines.svh"

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RULES);

    // control state
    state_t state_reg, state_next;
    logic   pass_sys_reg;                 // current pass is the system-wide pre-check
    logic   pass_sys_next;

    // latched item
    opcode_t     op_reg;
    rule_t       rule_in_reg;             // also holds request fields
    logic [15:0] ctry_fold_reg;
    logic        ctry_ok_reg;

    // table bookkeeping and counters
    logic [CNT_W-1:0] slots_used_reg;
    logic [CNT_W-1:0] live_count_reg;
    logic [31:0]      check_counter_reg;
    logic [31:0]      deny_counter_reg;

    // result
    logic    allowed_reg;
    status_t status_reg;

    // cell row wiring
    req_t                 req;
    flags_t               cell_flags [MAX_RULES];
    logic [MAX_RULES-1:0] deny_vec, allow_any_vec, allow_hit_vec;
    logic [MAX_RULES:0]   found_chain;
    cell_ctl_t            cell_ctl [MAX_RULES];

    // strobes from the sequencer
    logic accept, eval_go, check_go, add_go, del_go, clear_go;
    logic verdict, found, pool_full;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    // broadcast request; system pass forces target to system-wide
    always_comb begin
        req.ident     = rule_in_reg.ident;
        req.target    = pass_sys_reg ? TARGET_SYSTEM : rule_in_reg.target;
        req.ip        = rule_in_reg.address;
        req.ctry_fold = ctry_fold_reg;
        req.ctry_ok   = ctry_ok_reg;
        req.asn       = rule_in_reg.asn;
    end

    assign found_chain[MAX_RULES] = 1'b0;

    generate
        for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
            always_comb begin
                cell_ctl[i].eval_en = eval_go;
                cell_ctl[i].wr_en   = add_go && !pool_full &&
                                      (slots_used_reg[IDX_W-1:0] == IDX_W'(i));
                cell_ctl[i].kill_en = del_go;
                cell_ctl[i].clear   = clear_go;
            end
            artc_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (cell_ctl[i]),
                .wr_rule   (rule_in_reg),
                .req       (req),
                .found_in  (found_chain[i+1]),
                .found_out (found_chain[i]),
                .flags     (cell_flags[i])
            );
            assign deny_vec[i]      = cell_flags[i].deny_hit;
            assign allow_any_vec[i] = cell_flags[i].allow_any;
            assign allow_hit_vec[i] = cell_flags[i].allow_hit;
        end
    endgenerate

    // an empty table gives no flags, hence allow
    assign verdict   = !((|deny_vec) || ((|allow_any_vec) && !(|allow_hit_vec)));
    assign found     = found_chain[0];
    assign pool_full = (slots_used_reg >= MAX_CNT);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        pass_sys_next = pass_sys_reg;
        eval_go       = 1'b0;
        check_go      = 1'b0;
        add_go        = 1'b0;
        del_go        = 1'b0;
        clear_go      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pass_sys_next = (opcode_t'(s_opcode) == OP_CHECK) && s_system_first;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                eval_go    = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                unique case (op_reg)
                    OP_CHECK: check_go = 1'b1;
                    OP_ADD:   add_go   = 1'b1;
                    OP_DEL:   del_go   = 1'b1;
                    OP_CLEAR: clear_go = 1'b1;
                    default:  clear_go = 1'b0;
                endcase
                if (op_reg == OP_CHECK && pass_sys_reg && verdict) begin
                    pass_sys_next = 1'b0;
                    state_next    = ST_EVAL;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_sys_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pass_sys_reg <= pass_sys_next;
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg              <= opcode_t'(s_opcode);
            rule_in_reg.ident   <= s_rule_id;
            rule_in_reg.kind    <= kind_t'(s_rule_kind);
            rule_in_reg.target  <= s_target;
            rule_in_reg.allow   <= s_rule_allow;
            rule_in_reg.enabled <= s_rule_enabled;
            rule_in_reg.address <= s_ip_value;
            rule_in_reg.mask    <= s_mask_value;
            rule_in_reg.country <= s_country;
            rule_in_reg.asn     <= s_asn;
            ctry_fold_reg       <= fold_code(s_country);
            ctry_ok_reg         <= s_country_present;
        end
    end

    // counters and table bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_used_reg    <= '0;
            live_count_reg    <= '0;
            check_counter_reg <= '0;
            deny_counter_reg  <= '0;
        end else begin
            if (check_go) begin
                check_counter_reg <= check_counter_reg + 32'd1;
                if (!verdict) begin
                    deny_counter_reg <= deny_counter_reg + 32'd1;
                end
            end
            if (add_go && !pool_full) begin
                slots_used_reg <= slots_used_reg + CNT_W'(1);
                live_count_reg <= live_count_reg + CNT_W'(1);
            end
            if (del_go && found) begin
                live_count_reg <= live_count_reg - CNT_W'(1);
            end
            if (clear_go) begin
                slots_used_reg <= '0;
                live_count_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_REDUCE) begin
            allowed_reg <= (op_reg == OP_CHECK) && verdict;
            if (add_go && pool_full) begin
                status_reg <= STAT_FULL;
            end else if (del_go && !found) begin
                status_reg <= STAT_NOTFOUND;
            end else begin
                status_reg <= STAT_OK;
            end
        end
    end

    assign m_allowed       = allowed_reg;
    assign m_status        = status_reg;
    assign m_rules_live    = 7'(live_count_reg);
    assign m_checks_total  = check_counter_reg;
    assign m_denials_total = deny_counter_reg;

    `ARTC_ASSERT_NOW(a_live_le_slots, 1'b1, live_count_reg <= slots_used_reg, "live count above slots used")
    `ARTC_ASSERT_NOW(a_no_overlap, 1'b1, !(s_ready && m_valid), "input and output open together")
    `ARTC_ASSERT_NOW(a_allow_only_check, m_valid && op_reg != OP_CHECK, !m_allowed, "allowed set on non-check item")
    `ARTC_ASSERT_NEXT(a_notfound_keeps, del_go && !found, live_count_reg == $past(live_count_reg), "failed delete changed live count")

endmodule

### sv/artc_cell.sv
module artc_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  artc_pkg::cell_ctl_t ctl,
    input  artc_pkg::rule_t    wr_rule,
    input  artc_pkg::req_t     req,
    input  logic               found_in,
    output logic               found_out,
    output artc_pkg::flags_t   flags
);
    import artc_pkg::*;

    logic   live_reg;
    rule_t  rule_reg;
    flags_t flags_reg;
    flags_t flags_next;
    logic   del_hit_reg;
    logic   del_hit_next;
    logic   en;
    logic   hit;

    always_comb begin
        en = live_reg && rule_reg.enabled &&
             (rule_reg.target == req.target || rule_reg.target == TARGET_SYSTEM);
        case (rule_reg.kind)
            KIND_EXACT:   hit = (req.ip == rule_reg.address);
            KIND_NETWORK: hit = ((req.ip & rule_reg.mask) ==
                                 (rule_reg.address & rule_reg.mask));
            KIND_COUNTRY: hit = req.ctry_ok && (fold_code(rule_reg.country) == req.ctry_fold);
            default:      hit = (req.asn != 32'd0) && (rule_reg.asn == req.asn);
        endcase
        flags_next.allow_any = en && rule_reg.allow;
        flags_next.allow_hit = en && rule_reg.allow && hit;
        flags_next.deny_hit  = en && !rule_reg.allow && hit;
        del_hit_next         = live_reg && (rule_reg.ident == req.ident);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
        end else if (ctl.clear) begin
            live_reg <= 1'b0;
        end else if (ctl.wr_en) begin
            live_reg <= 1'b1;
        end else if (ctl.kill_en && del_hit_reg && !found_in) begin
            live_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            rule_reg <= wr_rule;
        end
        if (ctl.eval_en) begin
            flags_reg   <= flags_next;
            del_hit_reg <= del_hit_next;
        end
    end

    // highest matching cell wins a delete
    assign found_out = found_in | del_hit_reg;
    assign flags     = flags_reg;

endmodule

### tb/access_rule_table_checker_chk.sv
module artc_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [31:0] s_rule_id,
    input  logic [2:0]  s_target,
    input  logic [1:0]  s_rule_kind,
    input  logic        s_rule_allow,
    input  logic        s_rule_enabled,
    input  logic [31:0] s_ip_value,
    input  logic [31:0] s_mask_value,
    input  logic [15:0] s_country,
    input  logic        s_country_present,
    input  logic [31:0] s_asn,
    input  logic        s_system_first,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_allowed,
    input  logic [1:0]  m_status,
    input  logic [6:0]  m_rules_live,
    input  logic [31:0] m_checks_total,
    input  logic [31:0] m_denials_total,
    output int          mismatches,
    output int          outstanding
);
    import artc_pkg::*;

    typedef struct {
        logic        allowed;
        status_t     status;
        logic [6:0]  live;
        logic [31:0] checks;
        logic [31:0] denials;
    } reply_t;

    // shadow copy of the rule table
    logic        rule_live    [MAX_RULES];
    logic [31:0] rule_ident   [MAX_RULES];
    kind_t       rule_kind    [MAX_RULES];
    logic [2:0]  rule_target  [MAX_RULES];
    logic        rule_allow   [MAX_RULES];
    logic        rule_enabled [MAX_RULES];
    logic [31:0] rule_addr    [MAX_RULES];
    logic [31:0] rule_netmask [MAX_RULES];
    logic [15:0] rule_country [MAX_RULES];
    logic [31:0] rule_asn     [MAX_RULES];
    int          slots_taken;
    int          live_rules;
    logic [31:0] check_tally;
    logic [31:0] deny_tally;

    reply_t replies_due[$];
    reply_t want;

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic logic [15:0] lower_letters(input logic [15:0] code);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = code[15:8];
        lo = code[7:0];
        if (hi >= "A" && hi <= "Z") hi = hi + 8'd32;
        if (lo >= "A" && lo <= "Z") lo = lo + 8'd32;
        return {hi, lo};
    endfunction

    // one counted pass over the table; 1 means allowed
    function automatic logic judge_request(input logic [2:0] tgt, input logic [31:0] ip,
                                           input logic [15:0] ctry, input logic cp,
                                           input logic [31:0] asn);
        logic any_allow;
        logic allow_hit;
        logic deny_hit;
        logic hit;
        any_allow = 0;
        allow_hit = 0;
        deny_hit  = 0;
        check_tally = check_tally + 32'd1;
        if (live_rules == 0) return 1'b1;
        for (int i = 0; i < MAX_RULES; i++) begin
            if (!rule_live[i] || !rule_enabled[i]) continue;
            if (rule_target[i] != tgt && rule_target[i] != TARGET_SYSTEM) continue;
            case (rule_kind[i])
                KIND_EXACT:   hit = (ip == rule_addr[i]);
                KIND_NETWORK: hit = ((ip & rule_netmask[i]) ==
                                     (rule_addr[i] & rule_netmask[i]));
                KIND_COUNTRY: hit = cp && (lower_letters(rule_country[i]) == lower_letters(ctry));
                default:      hit = (asn != 0) && (rule_asn[i] == asn);
            endcase
            if (rule_allow[i]) begin
                any_allow = 1;
                if (hit) allow_hit = 1;
            end else if (hit) begin
                deny_hit = 1;
            end
        end
        if (deny_hit || (any_allow && !allow_hit)) begin
            deny_tally = deny_tally + 32'd1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_item();
        reply_t r;
        int     s;
        r.allowed = 0;
        r.status  = STAT_OK;
        case (opcode_t'(s_opcode))
            OP_CHECK: begin
                if (s_system_first && !judge_request(TARGET_SYSTEM, s_ip_value, s_country,
                                                     s_country_present, s_asn))
                    r.allowed = 0;
                else
                    r.allowed = judge_request(s_target, s_ip_value, s_country,
                                              s_country_present, s_asn);
            end
            OP_ADD: begin
                if (slots_taken >= MAX_RULES) begin
                    r.status = STAT_FULL;
                end else begin
                    s = slots_taken;
                    rule_live[s]    = 1;
                    rule_ident[s]   = s_rule_id;
                    rule_kind[s]    = kind_t'(s_rule_kind);
                    rule_target[s]  = s_target;
                    rule_allow[s]   = s_rule_allow;
                    rule_enabled[s] = s_rule_enabled;
                    rule_addr[s]    = s_ip_value;
                    rule_netmask[s] = s_mask_value;
                    rule_country[s] = s_country;
                    rule_asn[s]     = s_asn;
                    slots_taken++;
                    live_rules++;
                end
            end
            OP_DEL: begin
                r.status = STAT_NOTFOUND;
                for (int i = MAX_RULES - 1; i >= 0; i--) begin
                    if (rule_live[i] && rule_ident[i] == s_rule_id) begin
                        rule_live[i] = 0;
                        live_rules--;
                        r.status = STAT_OK;
                        break;
                    end
                end
            end
            default: begin
                foreach (rule_live[i]) rule_live[i] = 0;
                slots_taken = 0;
                live_rules  = 0;
            end
        endcase
        r.live    = live_rules[6:0];
        r.checks  = check_tally;
        r.denials = deny_tally;
        replies_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got,
                 exp_val);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (rule_live[i]) rule_live[i] = 0;
            slots_taken = 0;
            live_rules  = 0;
            check_tally = 0;
            deny_tally  = 0;
            replies_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_status), 32'd0);
                end else begin
                    want = replies_due.pop_front();
                    if (m_allowed !== want.allowed)
                        report_mismatch("allowed", 32'(m_allowed), 32'(want.allowed));
                    if (m_status !== want.status)
                        report_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_rules_live !== want.live)
                        report_mismatch("rules_live", 32'(m_rules_live), 32'(want.live));
                    if (m_checks_total !== want.checks)
                        report_mismatch("checks_total", m_checks_total, want.checks);
                    if (m_denials_total !== want.denials)
                        report_mismatch("denials_total", m_denials_total, want.denials);
                end
            end
            if (s_valid && s_ready) predict_item();
        end
        outstanding = replies_due.size();
    end

endmodule

### tb/access_rule_table_checker_tb.sv
module access_rule_table_checker_tb;
    import artc_pkg::*;

    localparam int ITEM_GOAL = 1650;

    typedef struct {
        opcode_t     op;
        logic [31:0] id;
        logic [2:0]  tgt;
        kind_t       kind;
        logic        allow;
        logic        en;
        logic [31:0] ip;
        logic [31:0] mask;
        logic [15:0] ctry;
        logic        cp;
        logic [31:0] asn;
        logic        sf;
    } request_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_opcode = 0;
    logic [31:0] s_rule_id = 0;
    logic [2:0]  s_target = 0;
    logic [1:0]  s_rule_kind = 0;
    logic        s_rule_allow = 0;
    logic        s_rule_enabled = 0;
    logic [31:0] s_ip_value = 0;
    logic [31:0] s_mask_value = 0;
    logic [15:0] s_country = 0;
    logic        s_country_present = 0;
    logic [31:0] s_asn = 0;
    logic        s_system_first = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_allowed;
    logic [1:0]  m_status;
    logic [6:0]  m_rules_live;
    logic [31:0] m_checks_total;
    logic [31:0] m_denials_total;
    int          mismatches;
    int          outstanding;

    // item tallies for the closing summary
    int          sent_by_op [4];
    int          items_sent;
    int          results_taken;

    // small pools so that requests actually hit stored rules
    logic [31:0] addr_pool [8];
    logic [31:0] asn_pool  [4];

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    access_rule_table_checker i_dut (.*);

    artc_result_checker i_chk (.*);

    // build one request from its fields
    function automatic request_t make_req(opcode_t op, logic [31:0] id, logic [2:0] tgt,
                                          kind_t kind, logic allow, logic en,
                                          logic [31:0] ip, logic [31:0] mask,
                                          logic [15:0] ctry, logic cp, logic [31:0] asn,
                                          logic sf);
        request_t r;
        r = '{op, id, tgt, kind, allow, en, ip, mask, ctry, cp, asn, sf};
        return r;
    endfunction

    // one letter of a country code, random case
    function automatic logic [7:0] pick_letter(input logic [7:0] upper);
        return ($urandom_range(0, 1) != 0) ? upper + 8'd32 : upper;
    endfunction

    // random request, mostly drawn from the pools with a share of raw noise
    function automatic request_t random_req();
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        r.op = (pick < 50) ? OP_CHECK : (pick < 88) ? OP_ADD : (pick < 98) ? OP_DEL : OP_CLEAR;
        r.id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 11);
        if ($urandom_range(0, 9) == 0)
            r.tgt = 3'($urandom_range(6, 7));
        else if ($urandom_range(0, 3) == 0)
            r.tgt = TARGET_SYSTEM;
        else
            r.tgt = 3'($urandom_range(0, 5));
        r.kind  = kind_t'($urandom_range(0, 3));
        r.allow = ($urandom_range(0, 2) == 0);
        r.en    = ($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 3) == 0)
            r.ip = $urandom;
        else
            r.ip = addr_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
        r.mask = ($urandom_range(0, 4) == 0) ? $urandom
                                             : (32'hFFFF_FFFF << $urandom_range(0, 32));
        case ($urandom_range(0, 3))
            0:       r.ctry = 16'($urandom_range(0, 16'hFFFF));
            1:       r.ctry = {pick_letter("D"), pick_letter("E")};
            default: r.ctry = {pick_letter("U"), pick_letter("S")};
        endcase
        r.cp = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
            0:       r.asn = 0;
            1:       r.asn = $urandom;
            default: r.asn = asn_pool[$urandom_range(0, 3)];
        endcase
        r.sf = ($urandom_range(0, 2) == 0);
        return r;
    endfunction

    // offer one item after an optional gap; returns on the edge it is taken
    task automatic send_item(input request_t r, input int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1;
        s_opcode          <= r.op;
        s_rule_id         <= r.id;
        s_target          <= r.tgt;
        s_rule_kind       <= r.kind;
        s_rule_allow      <= r.allow;
        s_rule_enabled    <= r.en;
        s_ip_value        <= r.ip;
        s_mask_value      <= r.mask;
        s_country         <= r.ctry;
        s_country_present <= r.cp;
        s_asn             <= r.asn;
        s_system_first    <= r.sf;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_by_op[r.op]++;
        items_sent++;
    endtask

    // hold the input back until every result in flight has come out
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // result side: random stalls, quiet stretches and two long hold-offs
    initial begin
        int  gap;
        bit  quiet;
        quiet = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 40) == 0) quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 15);
            // long stall so the block backs up and stops taking items
            if (results_taken == 200 || results_taken == 900) gap = 300;
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_taken++;
        end
    end

    // stimulus
    initial begin
        request_t directed [$];
        int       phase_len;
        int       gap;
        bit       quiet;
        bit       drained_once;

        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        foreach (asn_pool[i]) asn_pool[i] = $urandom_range(1, 32'hFFFF_FFFF);
        quiet = 0;
        drained_once = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty table lets everything through, extreme field values
        directed.push_back(make_req(OP_CHECK, 32'hFFFF_FFFF, 3'd7, KIND_ASN, 1, 1,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                    32'hFFFF_FFFF, 1));
        // exact deny for master: hit on master, ignored for slave
        directed.push_back(make_req(OP_ADD, 1, 3'd1, KIND_EXACT, 0, 1, 32'h0A00_0001, 0,
                                    0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd1, KIND_EXACT, 0, 0, 32'h0A00_0001, 0,
                                    0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd2, KIND_EXACT, 0, 0, 32'h0A00_0001, 0,
                                    0, 0, 0, 0));
        // system-wide network allow, then a hit and a miss
        directed.push_back(make_req(OP_ADD, 2, TARGET_SYSTEM, KIND_NETWORK, 1, 1,
                                    32'hC0A8_0000, 32'hFFFF_0000, 0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd2, KIND_EXACT, 0, 0, 32'hC0A8_1234, 0,
                                    0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd2, KIND_EXACT, 0, 0, 32'h0000_0000, 0,
                                    0, 0, 0, 0));
        // country allow with mixed case, with and without a code on the request
        directed.push_back(make_req(OP_ADD, 3, 3'd2, KIND_COUNTRY, 1, 1, 0, 0, "Us", 0, 0,
                                    0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd2, KIND_EXACT, 0, 0, 32'h0101_0101, 0,
                                    "uS", 1, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd2, KIND_EXACT, 0, 0, 32'h0101_0101, 0,
                                    "uS", 0, 0, 0));
        // AS number deny; a request asn of zero never matches
        directed.push_back(make_req(OP_ADD, 4, 3'd3, KIND_ASN, 0, 1, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd3, KIND_EXACT, 0, 0, 32'hC0A8_0001, 0,
                                    0, 0, 0, 0));
        directed.push_back(make_req(OP_ADD, 5, 3'd4, KIND_ASN, 0, 1, 0, 0, 0, 0, 65001, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd4, KIND_EXACT, 0, 0, 32'hC0A8_0001, 0,
                                    0, 0, 65001, 1));
        // system-first: a system deny ends it after one counted pass
        directed.push_back(make_req(OP_ADD, 6, TARGET_SYSTEM, KIND_EXACT, 0, 1,
                                    32'hC0A8_0009, 0, 0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd5, KIND_EXACT, 0, 0, 32'hC0A8_0009, 0,
                                    0, 0, 0, 1));
        // disabled rule and target code seven
        directed.push_back(make_req(OP_ADD, 7, 3'd7, KIND_EXACT, 0, 0, 32'h0A00_0002, 0, 0,
                                    0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd7, KIND_EXACT, 0, 0, 32'h0A00_0002, 0,
                                    0, 0, 0, 0));
        // duplicate ids: delete takes the newest, then id not found
        directed.push_back(make_req(OP_ADD, 9, 3'd1, KIND_EXACT, 0, 1, 32'h0A00_0003, 0, 0,
                                    0, 0, 0));
        directed.push_back(make_req(OP_ADD, 9, 3'd1, KIND_EXACT, 0, 1, 32'h0A00_0004, 0, 0,
                                    0, 0, 0));
        directed.push_back(make_req(OP_DEL, 9, 0, KIND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd1, KIND_EXACT, 0, 0, 32'h0A00_0003, 0,
                                    0, 0, 0, 0));
        directed.push_back(make_req(OP_DEL, 32'hDEAD_BEEF, 0, KIND_EXACT, 0, 0, 0, 0, 0, 0,
                                    0, 0));
        directed.push_back(make_req(OP_CLEAR, 0, 0, KIND_EXACT, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(OP_CHECK, 0, 3'd1, KIND_EXACT, 0, 0, 32'h0A00_0003, 0,
                                    0, 0, 0, 0));
        foreach (directed[i]) send_item(directed[i], $urandom_range(0, 2));

        // random phases, most starting from a cleared table so that the pool
        // fills up again; long phases run into pool exhaustion
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(0, 3) != 0)
                send_item(make_req(OP_CLEAR, $urandom, 3'($urandom),
                                   kind_t'($urandom_range(0, 3)), 1'($urandom),
                                   1'($urandom), $urandom, $urandom, 16'($urandom),
                                   1'($urandom), $urandom, 1'($urandom)), 0);
            phase_len = $urandom_range(20, 160);
            if (phase_len > ITEM_GOAL - items_sent) phase_len = ITEM_GOAL - items_sent;
            repeat (phase_len) begin
                if ($urandom_range(0, 40) == 0) quiet = !quiet;
                gap = quiet ? 0 : $urandom_range(0, 15);
                send_item(random_req(), gap);
            end
            // pause until the block has answered everything, at least once
            if (!drained_once || $urandom_range(0, 3) == 0) begin
                drain();
                drained_once = 1;
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("sent %0d items: %0d checks, %0d adds, %0d deletes, %0d clears",
                 items_sent, sent_by_op[OP_CHECK], sent_by_op[OP_ADD], sent_by_op[OP_DEL],
                 sent_by_op[OP_CLEAR]);
        $display("took %0d results, %0d mismatches", results_taken, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #2000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/artc_pkg.sv
sv/artc_cell.sv
sv/access_rule_table_checker.sv
tb/access_rule_table_checker_chk.sv
tb/access_rule_table_checker_tb.sv
